// ===== rtl/tkrl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkrl_pkg
// Shared types, constants and the ranking compare for the ranked list.
// ----------------------------------------------------------------------------
package tkrl_pkg;

  localparam int MAX_RECORDS  = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int KEY_W        = 16;
  localparam int SCORE_W      = 10;
  localparam int CMD_W        = 2;
  localparam int RANK_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W        = $clog2(MAX_RECORDS + 1);
  localparam int LIMIT_W      = 5;
  localparam int READ_RANK_W  = 4;
  localparam int OUT_PAY_W    = 32;
  localparam int OUT_RANK_W   = 4;
  localparam int OUT_CNT_W    = 5;

  localparam logic [CMD_W-1:0] CMD_MERGE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic [SCORE_W-1:0]      score;
    logic [PAYLOAD_BITS-1:0] payload;
  } rec_t;

  typedef struct packed {
    logic del_en;
    logic ins_en;
    rec_t cand;
  } cell_ctl_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0]  entry_count;
    logic                  was_replaced;
    logic                  was_inserted;
    logic [OUT_RANK_W-1:0] insert_rank;
    logic                  read_valid;
    logic [KEY_W-1:0]      read_key;
    logic [SCORE_W-1:0]    read_score;
    logic [OUT_PAY_W-1:0]  read_payload;
  } res_t;

  function automatic logic beats(input rec_t a, input rec_t b);
    logic r;
    if (a.score != b.score) begin
      r = a.score > b.score;
    end else begin
      r = a.key < b.key;
    end
    return r;
  endfunction

endpackage

// ===== rtl/tkrl_item_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkrl_item_if
// Input channel: command word with record fields and read rank.
// ----------------------------------------------------------------------------
interface tkrl_item_if;
  logic                                valid;
  logic                                ready;
  logic [tkrl_pkg::CMD_W-1:0]          command;
  logic [tkrl_pkg::KEY_W-1:0]          entry_key;
  logic [tkrl_pkg::SCORE_W-1:0]        entry_score;
  logic                                entry_excluded;
  logic [tkrl_pkg::PAYLOAD_BITS-1:0]   entry_payload;
  logic [tkrl_pkg::READ_RANK_W-1:0]    read_rank;

  modport source (
    output valid, command, entry_key, entry_score, entry_excluded, entry_payload,
           read_rank,
    input  ready
  );

  modport sink (
    input  valid, command, entry_key, entry_score, entry_excluded, entry_payload,
           read_rank,
    output ready
  );
endinterface

// ===== rtl/tkrl_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkrl_res_if
// Result channel: list status, merge outcome and read data.
// ----------------------------------------------------------------------------
interface tkrl_res_if;
  logic                               valid;
  logic                               ready;
  logic [tkrl_pkg::OUT_CNT_W-1:0]     entry_count;
  logic                               was_replaced;
  logic                               was_inserted;
  logic [tkrl_pkg::OUT_RANK_W-1:0]    insert_rank;
  logic                               read_valid;
  logic [tkrl_pkg::KEY_W-1:0]         read_key;
  logic [tkrl_pkg::SCORE_W-1:0]       read_score;
  logic [tkrl_pkg::OUT_PAY_W-1:0]     read_payload;

  modport source (
    output valid, entry_count, was_replaced, was_inserted, insert_rank, read_valid,
           read_key, read_score, read_payload,
    input  ready
  );

  modport sink (
    input  valid, entry_count, was_replaced, was_inserted, insert_rank, read_valid,
           read_key, read_score, read_payload,
    output ready
  );
endinterface

// ===== rtl/tkrl_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkrl_cell
// One ranked place: holds a record, closes the gap on removal, opens one on
// insertion.
// ----------------------------------------------------------------------------
module tkrl_cell (
  input  logic                  clk_i,
  input  tkrl_pkg::cell_ctl_t   ctl_i,
  input  logic                  valid_i,
  input  tkrl_pkg::rec_t        prev_rec_i,
  input  tkrl_pkg::rec_t        next_rec_i,
  input  logic                  found_i,
  input  logic                  pos_i,
  output tkrl_pkg::rec_t        rec_o,
  output logic                  found_o,
  output logic                  pos_o
);

  tkrl_pkg::rec_t rec_q;
  tkrl_pkg::rec_t rec_d;

  assign found_o = found_i | (valid_i & (rec_q.key == ctl_i.cand.key));
  assign pos_o   = ~valid_i | tkrl_pkg::beats(ctl_i.cand, rec_q);
  assign rec_o   = rec_q;

  always_comb begin
    rec_d = rec_q;
    if (ctl_i.del_en && found_o) begin
      rec_d = next_rec_i;
    end else if (ctl_i.ins_en && pos_i) begin
      rec_d = prev_rec_i;
    end else if (ctl_i.ins_en && pos_o) begin
      rec_d = ctl_i.cand;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

endmodule

// ===== rtl/top_k_ranked_list_with_replace.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_ranked_list_with_replace
// Best-first list of scored records kept in a row of sixteen cells.
// ----------------------------------------------------------------------------
// A merge word is worked in a removal step and an insert step: in the cycle
// it is accepted the cell row drops any record with the same key and closes
// the gap, and in the next cycle the row opens a place and writes the new
// record, each cell taking its neighbour's record. Read, clear and unknown
// commands, and merges while list_limit is zero, finish when accepted.
// One word is worked on at a time; a word is accepted only while the result
// register is free or being emptied. The list needs no clearing after reset.
// Write list_limit only while no word is in flight.
module top_k_ranked_list_with_replace (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tkrl_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  tkrl_item_if.sink                     items_i,
  tkrl_res_if.source                    results_o
);

  localparam int          N        = tkrl_pkg::MAX_RECORDS;
  localparam int          CW       = tkrl_pkg::CNT_W;
  localparam logic        ST_IDLE  = 1'b0;
  localparam logic        ST_INS   = 1'b1;
  localparam logic [CW-1:0] MAX_CNT = CW'(N);

  logic                          state_q, state_d;
  logic [tkrl_pkg::LIMIT_W-1:0]  limit_q;
  logic [CW-1:0]                 count_q, count_d;
  tkrl_pkg::rec_t                item_q;
  logic                          excl_q;
  logic                          repl_q;
  tkrl_pkg::res_t                res_q, res_d;
  logic                          res_valid_q, res_valid_d;

  logic [CW-1:0]                 lim_eff;
  logic [CW-1:0]                 cnt_trunc;
  logic [CW-1:0]                 cnt_view;
  logic                          accept;
  logic                          merge_acc;
  logic                          produce;
  logic                          res_free;
  tkrl_pkg::rec_t                port_rec;
  tkrl_pkg::cell_ctl_t           ctl;
  logic [CW-1:0]                 at;
  logic                          ins_ok;

  tkrl_pkg::rec_t                rec_w   [N];
  logic [N-1:0]                  valid_w;
  logic [N-1:0]                  found_w;
  logic [N-1:0]                  pos_w;
  tkrl_pkg::rec_t                rd_rec;

  assign lim_eff   = (CW'(limit_q) > MAX_CNT) ? MAX_CNT : CW'(limit_q);
  assign cnt_trunc = (count_q > lim_eff) ? lim_eff : count_q;
  assign cnt_view  = (state_q == ST_IDLE) ? cnt_trunc : count_q;

  assign res_free       = ~res_valid_q | results_o.ready;
  assign items_i.ready  = (state_q == ST_IDLE) & res_free;
  assign accept         = items_i.valid & items_i.ready;
  assign merge_acc      = accept & (items_i.command == tkrl_pkg::CMD_MERGE)
                          & (lim_eff != '0);

  assign port_rec.key     = items_i.entry_key;
  assign port_rec.score   = items_i.entry_score;
  assign port_rec.payload = items_i.entry_payload;

  // insertion point: first place the candidate beats or that is empty
  always_comb begin
    at = MAX_CNT;
    for (int i = N - 1; i >= 0; i--) begin
      if (pos_w[i]) begin
        at = CW'(i);
      end
    end
  end

  assign ins_ok      = (state_q == ST_INS) & ~excl_q & (at < lim_eff);
  assign ctl.del_en  = merge_acc;
  assign ctl.ins_en  = ins_ok;
  assign ctl.cand    = (state_q == ST_INS) ? item_q : port_rec;

  for (genvar g = 0; g < N; g++) begin : g_cell
    assign valid_w[g] = CW'(g) < cnt_view;

    tkrl_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .valid_i    (valid_w[g]),
      .prev_rec_i ((g == 0) ? ctl.cand : rec_w[(g == 0) ? 0 : g - 1]),
      .next_rec_i ((g == N - 1) ? rec_w[g] : rec_w[(g == N - 1) ? g : g + 1]),
      .found_i    ((g == 0) ? 1'b0 : found_w[(g == 0) ? 0 : g - 1]),
      .pos_i      ((g == 0) ? 1'b0 : pos_w[(g == 0) ? 0 : g - 1]),
      .rec_o      (rec_w[g]),
      .found_o    (found_w[g]),
      .pos_o      (pos_w[g])
    );
  end

  assign rd_rec = rec_w[items_i.read_rank[tkrl_pkg::RANK_W-1:0]];

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    res_d       = res_q;
    produce     = 1'b0;
    res_valid_d = res_valid_q & ~results_o.ready;

    if (state_q == ST_INS) begin
      if (ins_ok && (count_q < lim_eff)) begin
        count_d = count_q + CW'(1);
      end
      produce            = 1'b1;
      res_d              = '0;
      res_d.entry_count  = tkrl_pkg::OUT_CNT_W'(count_d);
      res_d.was_replaced = repl_q;
      res_d.was_inserted = ins_ok;
      res_d.insert_rank  = ins_ok ? tkrl_pkg::OUT_RANK_W'(at) : '0;
      state_d            = ST_IDLE;
    end else if (merge_acc) begin
      count_d = cnt_trunc - CW'(found_w[N-1]);
      state_d = ST_INS;
    end else if (accept) begin
      produce = 1'b1;
      res_d   = '0;
      case (items_i.command)
        tkrl_pkg::CMD_READ: begin
          if (CW'(items_i.read_rank) < count_q) begin
            res_d.read_valid   = 1'b1;
            res_d.read_key     = rd_rec.key;
            res_d.read_score   = rd_rec.score;
            res_d.read_payload = tkrl_pkg::OUT_PAY_W'(rd_rec.payload);
          end
        end
        tkrl_pkg::CMD_CLEAR: begin
          count_d = '0;
        end
        default: begin
        end
      endcase
      res_d.entry_count = tkrl_pkg::OUT_CNT_W'(count_d);
    end

    if (produce) begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      limit_q     <= tkrl_pkg::LIMIT_W'(N);
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (merge_acc) begin
      item_q <= port_rec;
      excl_q <= items_i.entry_excluded;
      repl_q <= found_w[N-1];
    end
    if (produce) begin
      res_q <= res_d;
    end
  end

  assign results_o.valid        = res_valid_q;
  assign results_o.entry_count  = res_q.entry_count;
  assign results_o.was_replaced = res_q.was_replaced;
  assign results_o.was_inserted = res_q.was_inserted;
  assign results_o.insert_rank  = res_q.insert_rank;
  assign results_o.read_valid   = res_q.read_valid;
  assign results_o.read_key     = res_q.read_key;
  assign results_o.read_score   = res_q.read_score;
  assign results_o.read_payload = res_q.read_payload;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_CNT)
    else $error("record count above depth");

  a_ins_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INS) |-> !res_valid_q)
    else $error("insert step with result register occupied");

  a_rank_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.was_inserted) |->
      (tkrl_pkg::OUT_CNT_W'(res_q.insert_rank) < res_q.entry_count))
    else $error("insert rank outside held records");

  a_merge_then_ins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge_acc |=> (state_q == ST_INS))
    else $error("merge word did not reach insert step");

endmodule
